// File: src/i2cm_pkg.sv
// Package for the I2C master byte sequencer: command codes, bus phase
// constants and the payload structs of the command and result channels.
// No dependencies.
`default_nettype none

package i2cm_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int PHASE_W = 5;
    localparam int SUB_W = 2;

    localparam logic [PHASE_W-1:0] WRITE_BIT_PHASES = PHASE_W'(3 * BITS_PER_BYTE);
    localparam logic [PHASE_W-1:0] READ_BIT_PHASES = PHASE_W'(2 * BITS_PER_BYTE);

    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } cmd_code_t;

    typedef enum logic [SUB_W-1:0] {
        SUB_DATA = 2'd0,
        SUB_HIGH = 2'd1,
        SUB_LOW  = 2'd2
    } sub_phase_t;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] data_byte;
        logic       send_ack;
        logic       sda_in;
    } cmd_t;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_received;
    } res_t;

endpackage

`default_nettype wire

// File: src/i2cm_stream_if.sv
// Valid/ready stream interface used for the command and result channels.
// The payload type is a parameter; it depends on nothing else.
`default_nettype none

interface i2cm_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: src/i2cm_phase_engine.sv
// Bus phase engine: command and phase state, and the next-phase logic that
// turns one command transfer into the bus levels of the following phase.
// Depends on i2cm_pkg.
`default_nettype none

module i2cm_phase_engine
    import i2cm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic step,
    input  wire cmd_t cmd,
    output res_t      res
);

    cmd_code_t          act_reg, act_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    sub_phase_t         sub_reg, sub_next;
    logic [7:0]         shift_reg, shift_next;
    logic               scl_reg, scl_next;
    logic               sda_reg, sda_next;
    logic               ack_reg, ack_next;
    logic               ack_send_reg, ack_send_next;
    logic [7:0]         last_read_reg, last_read_next;
    logic               busy;
    logic               done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg       <= CMD_IDLE;
            phase_reg     <= '0;
            sub_reg       <= SUB_DATA;
            shift_reg     <= '0;
            scl_reg       <= 1'b0;
            sda_reg       <= 1'b1;
            ack_reg       <= 1'b0;
            ack_send_reg  <= 1'b1;
            last_read_reg <= '0;
        end
        else if (step)
        begin
            act_reg       <= act_next;
            phase_reg     <= phase_next;
            sub_reg       <= sub_next;
            shift_reg     <= shift_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            ack_reg       <= ack_next;
            ack_send_reg  <= ack_send_next;
            last_read_reg <= last_read_next;
        end
    end

    always_comb
    begin
        act_next       = act_reg;
        phase_next     = phase_reg;
        sub_next       = sub_reg;
        shift_next     = shift_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        ack_next       = ack_reg;
        ack_send_next  = ack_send_reg;
        last_read_next = last_read_reg;
        done           = 1'b0;

        // An idle engine launches a command; its first phase runs in the same step.
        if (act_reg == CMD_IDLE && cmd.operation >= CMD_START && cmd.operation <= CMD_READ)
        begin
            act_next   = cmd_code_t'(cmd.operation);
            phase_next = '0;
            sub_next   = SUB_DATA;
            if (cmd.operation == CMD_WRITE)
            begin
                shift_next = cmd.data_byte;
            end
            else if (cmd.operation == CMD_READ)
            begin
                shift_next    = '0;
                ack_send_next = cmd.send_ack;
            end
        end

        busy = (act_next != CMD_IDLE);

        unique case (act_next)
            CMD_START:
            begin
                case (phase_next)
                    5'd0: scl_next = 1'b0;
                    5'd1: sda_next = 1'b1;
                    5'd2: scl_next = 1'b1;
                    5'd3: sda_next = 1'b0;
                    default:
                    begin
                        scl_next = 1'b0;
                        done     = 1'b1;
                    end
                endcase
            end
            CMD_STOP:
            begin
                case (phase_next)
                    5'd0: scl_next = 1'b0;
                    5'd1: sda_next = 1'b0;
                    5'd2: scl_next = 1'b1;
                    default:
                    begin
                        sda_next = 1'b1;
                        done     = 1'b1;
                    end
                endcase
            end
            CMD_WRITE:
            begin
                if (phase_next < WRITE_BIT_PHASES)
                begin
                    unique case (sub_next)
                        SUB_DATA:
                        begin
                            sda_next = shift_next[BITS_PER_BYTE-1];
                            sub_next = SUB_HIGH;
                        end
                        SUB_HIGH:
                        begin
                            scl_next = 1'b1;
                            sub_next = SUB_LOW;
                        end
                        default:
                        begin
                            scl_next   = 1'b0;
                            shift_next = {shift_next[BITS_PER_BYTE-2:0], 1'b0};
                            sub_next   = SUB_DATA;
                        end
                    endcase
                end
                else if (phase_next == WRITE_BIT_PHASES)
                begin
                    sda_next = 1'b1;
                end
                else if (phase_next == WRITE_BIT_PHASES + PHASE_W'(1))
                begin
                    scl_next = 1'b1;
                end
                else
                begin
                    ack_next = ~cmd.sda_in;
                    scl_next = 1'b0;
                    done     = 1'b1;
                end
            end
            CMD_READ:
            begin
                if (phase_next == '0)
                begin
                    scl_next = 1'b0;
                    sda_next = 1'b1;
                end
                else if (phase_next <= READ_BIT_PHASES)
                begin
                    if (phase_next[0])
                    begin
                        scl_next = 1'b1;
                    end
                    else
                    begin
                        shift_next = {shift_next[BITS_PER_BYTE-2:0], cmd.sda_in};
                        scl_next   = 1'b0;
                    end
                end
                else if (phase_next == READ_BIT_PHASES + PHASE_W'(1))
                begin
                    sda_next = ack_send_next;
                end
                else if (phase_next == READ_BIT_PHASES + PHASE_W'(2))
                begin
                    scl_next = 1'b1;
                end
                else
                begin
                    scl_next       = 1'b0;
                    last_read_next = shift_next;
                    done           = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (done)
        begin
            act_next   = CMD_IDLE;
            phase_next = '0;
        end
        else if (busy)
        begin
            phase_next = phase_next + PHASE_W'(1);
        end

        res.scl          = scl_next;
        res.sda_out      = sda_next;
        res.busy_res     = busy;
        res.done_res     = done;
        res.read_byte    = last_read_next;
        res.ack_received = ack_next;
    end

endmodule

`default_nettype wire

// File: src/i2c_master_byte_sequencer.sv
// Top level of the I2C master byte sequencer: command input register, the
// phase engine and the result register. Depends on i2cm_pkg, i2cm_stream_if
// and i2cm_phase_engine.
//
//   Channel  Direction  Payload                                   Per transfer
//   cmd      in         operation, data_byte, send_ack, sda_in    one bus phase
//   res      out        scl, sda_out, busy_res, done_res,         one result
//                       read_byte, ack_received
//
// Every command transfer yields exactly one result transfer, via the input
// and result registers. One transfer is taken per cycle unless the result
// side stalls; the rate is set by the single engine step between them.
// Reset leaves the engine idle with SCL low and SDA released.
// A stalled result holds the result register; one more command can wait in
// the input register before cmd.ready falls.
`default_nettype none

module i2c_master_byte_sequencer
    import i2cm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    i2cm_stream_if.sink   cmd,
    i2cm_stream_if.source res
);

    logic in_valid_reg;
    cmd_t in_data_reg;
    logic out_valid_reg;
    res_t out_data_reg;
    res_t step_res;
    logic advance;

    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign cmd.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ready)
            begin
                in_valid_reg <= cmd.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            in_data_reg <= cmd.payload;
        end
        if (advance)
        begin
            out_data_reg <= step_res;
        end
    end

    i2cm_phase_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .cmd   (in_data_reg),
        .res   (step_res)
    );

    assign res.valid   = out_valid_reg;
    assign res.payload = out_data_reg;

endmodule

`default_nettype wire

// File: src/i2cm_checker.sv
// Port-level checks for the I2C master byte sequencer, attached by bind.
// Depends on i2cm_pkg and on the top level's channel signals.
`default_nettype none

module i2cm_checker
    import i2cm_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic cmd_valid,
    input wire logic cmd_ready,
    input wire logic res_valid,
    input wire logic res_ready,
    input wire res_t res_payload
);

    logic [1:0] pending_reg;
    logic       seen_reg;
    res_t       last_reg;
    logic       cmd_xfer;
    logic       res_xfer;

    assign cmd_xfer = cmd_valid && cmd_ready;
    assign res_xfer = res_valid && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            seen_reg    <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_reg + 2'(cmd_xfer) - 2'(res_xfer);
            if (res_xfer)
            begin
                seen_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_xfer)
        begin
            last_reg <= res_payload;
        end
    end

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 2'd2)
        else $error("More than two transfers in flight.");

    a_no_orphan_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pending_reg != 2'd0)
        else $error("Result offered with no command outstanding.");

    a_done_is_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_payload.done_res |-> res_payload.busy_res)
        else $error("Final phase reported while not busy.");

    a_idle_holds_bus: assert property (@(posedge clk) disable iff (!rst_n)
        res_xfer && seen_reg && !res_payload.busy_res && !last_reg.busy_res
        |-> res_payload.scl == last_reg.scl && res_payload.sda_out == last_reg.sda_out
            && res_payload.read_byte == last_reg.read_byte)
        else $error("Bus levels changed while idle.");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_payload))
        else $error("Stalled result changed.");

endmodule

bind i2c_master_byte_sequencer i2cm_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .res_payload (res.payload)
);

`default_nettype wire
